### design/frps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frps_pkg
// Shared types and constants of the fixed-radius point search.
// ----------------------------------------------------------------------------
package frps_pkg;

   // table geometry
   localparam int MAX_POINTS = 256;
   localparam int IDX_W      = 8;
   localparam int CNT_W      = 9;
   localparam int COORD_W    = 16;
   localparam int POINT_W    = 3 * COORD_W;
   localparam int WORD_BITS  = 64;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int WIDX_W     = 2;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int DIST_W     = SQ_W + 2;

   // largest usable count: table size, capped by four mask words
   localparam int CAP_POINTS = (MAX_POINTS < 4 * WORD_BITS) ? MAX_POINTS : 4 * WORD_BITS;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(CAP_POINTS);

   // input command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // register indexes
   localparam logic REG_THRESHOLD  = 1'b0;
   localparam logic REG_NODE_COUNT = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRC,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT,
      ST_MISS
   } state_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [COORD_W-1:0] threshold;
      logic [CNT_W-1:0]   count;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic write_en;
      logic query_start;
      logic src_latch;
      logic scan_step;
      logic emit_hit;
      logic emit_miss;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic src_found;
      logic word_end;
      logic pipe_busy;
      logic out_free;
      logic last;
   } status_type;

endpackage
`default_nettype wire

### design/frps_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frps_regs
// Configuration registers: threshold and node count behind a simple
// APB-style port, plus the usable point count.
// ----------------------------------------------------------------------------
module frps_regs
   import frps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   logic [COORD_W-1:0] threshold_ff;
   logic [CNT_W-1:0]   node_count_ff;
   logic               wr_strobe;

   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= '0;
         node_count_ff <= CNT_W'(216);
      end else if (wr_strobe) begin
         case (csr_paddr[2])
            REG_THRESHOLD:  threshold_ff  <= csr_pwdata[COORD_W-1:0];
            REG_NODE_COUNT: node_count_ff <= csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (csr_paddr[2])
         REG_THRESHOLD:  csr_prdata = {{(32-COORD_W){1'b0}}, threshold_ff};
         REG_NODE_COUNT: csr_prdata = {{(32-CNT_W){1'b0}}, node_count_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // usable count saturates at the table and mask capacity
   assign cfg.threshold = threshold_ff;
   assign cfg.count     = (node_count_ff > MAX_CNT) ? MAX_CNT : node_count_ff;

endmodule
`default_nettype wire

### design/frps_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frps_ctrl
// Sequencer: accepts items, walks the table one point a cycle per mask
// word, waits for the pipeline to drain and hands each word out.
// ----------------------------------------------------------------------------
module frps_ctrl
   import frps_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   input  wire logic  req_cmd,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_cmd == CMD_QUERY)) begin
               state_in = status.src_found ? ST_SRC : ST_MISS;
            end
         end
         ST_SRC:   state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.word_end) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = status.last ? ST_IDLE : ST_SCAN;
         end
         ST_MISS: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      req_stall       = 1'b1;
      cmd             = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            cmd.write_en    = req_valid && (req_cmd == CMD_WRITE);
            cmd.query_start = req_valid && (req_cmd == CMD_QUERY);
         end
         ST_SRC:   cmd.src_latch = 1'b1;
         ST_SCAN:  cmd.scan_step = 1'b1;
         ST_DRAIN: ;
         ST_EMIT:  cmd.emit_hit  = status.out_free;
         ST_MISS:  cmd.emit_miss = status.out_free;
         default:  ;
      endcase
   end

endmodule
`default_nettype wire

### design/frps_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frps_datapath
// Point table, source latch, distance pipeline (read, difference, square,
// sum and compare), mask accumulator and result register.
// ----------------------------------------------------------------------------
module frps_datapath
   import frps_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  cfg_type                        cfg,
   input  cmd_type                        cmd,
   output status_type                     status,
   input  wire logic        [IDX_W-1:0]   req_node_index,
   input  wire logic signed [COORD_W-1:0] req_valence,
   input  wire logic signed [COORD_W-1:0] req_arousal,
   input  wire logic signed [COORD_W-1:0] req_intensity,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [WORD_BITS-1:0]           rsp_match_mask,
   output logic [WIDX_W-1:0]              rsp_word_index,
   output logic                           rsp_source_found,
   output logic                           rsp_last
);

   // absolute difference of two signed coordinates
   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] m;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      m = d[COORD_W] ? (~d + 1'b1) : d;
      return m[COORD_W-1:0];
   endfunction

   logic [POINT_W-1:0]   pt_mem [MAX_POINTS];
   logic [POINT_W-1:0]   rd_data_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic [POINT_W-1:0]   src_ff;
   logic [IDX_W-1:0]     src_idx_ff;
   logic [SQ_W-1:0]      thr2_ff;
   logic [CNT_W-1:0]     scan_id_ff;
   logic [WIDX_W-1:0]    word_ff;
   logic                 last_ff;
   logic                 query_end;
   logic [WORD_BITS-1:0] acc_ff;

   logic                 p0_valid_ff, p1_valid_ff, p2_valid_ff;
   logic [BIT_W-1:0]     p0_bit_ff, p1_bit_ff, p2_bit_ff;
   logic                 p0_excl_ff, p1_excl_ff, p2_excl_ff;
   logic [COORD_W-1:0]   p1_dv_ff, p1_da_ff, p1_di_ff;
   logic [SQ_W-1:0]      p2_sv_ff, p2_sa_ff, p2_si_ff;
   logic [DIST_W-1:0]    dist2;
   logic                 hit;

   logic                 rsp_valid_ff;
   logic [WORD_BITS-1:0] rsp_mask_ff;
   logic [WIDX_W-1:0]    rsp_word_ff;
   logic                 rsp_found_ff;
   logic                 rsp_last_ff;
   logic                 out_free;

   // point table, one write and one registered read
   assign rd_addr = cmd.query_start ? req_node_index : scan_id_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.write_en && ({1'b0, req_node_index} < CNT_W'(MAX_POINTS))) begin
         pt_mem[req_node_index] <= {req_valence, req_arousal, req_intensity};
      end
      if (cmd.query_start || cmd.scan_step) begin
         rd_data_ff <= pt_mem[rd_addr];
      end
   end

   // source point and squared radius
   always_ff @(posedge clock) begin
      thr2_ff <= cfg.threshold * cfg.threshold;
      if (cmd.query_start) src_idx_ff <= req_node_index;
      if (cmd.src_latch)   src_ff     <= rd_data_ff;
   end

   // scan position, word number and end of query
   assign query_end = (scan_id_ff + CNT_W'(1)) == cfg.count;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_id_ff <= '0;
         word_ff    <= '0;
         last_ff    <= 1'b0;
      end else if (cmd.query_start) begin
         scan_id_ff <= '0;
         word_ff    <= '0;
         last_ff    <= 1'b0;
      end else begin
         if (cmd.scan_step) begin
            scan_id_ff <= scan_id_ff + CNT_W'(1);
            if (query_end) last_ff <= 1'b1;
         end
         if (cmd.emit_hit) word_ff <= word_ff + WIDX_W'(1);
      end
   end

   // pipeline valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p0_valid_ff <= cmd.scan_step;
         p1_valid_ff <= p0_valid_ff;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   // pipeline payload: tag, abs differences, squares
   always_ff @(posedge clock) begin
      p0_bit_ff  <= scan_id_ff[BIT_W-1:0];
      p0_excl_ff <= scan_id_ff[IDX_W-1:0] == src_idx_ff;
      p1_bit_ff  <= p0_bit_ff;
      p1_excl_ff <= p0_excl_ff;
      p1_dv_ff   <= abs_diff(src_ff[3*COORD_W-1:2*COORD_W], rd_data_ff[3*COORD_W-1:2*COORD_W]);
      p1_da_ff   <= abs_diff(src_ff[2*COORD_W-1:COORD_W], rd_data_ff[2*COORD_W-1:COORD_W]);
      p1_di_ff   <= abs_diff(src_ff[COORD_W-1:0], rd_data_ff[COORD_W-1:0]);
      p2_bit_ff  <= p1_bit_ff;
      p2_excl_ff <= p1_excl_ff;
      p2_sv_ff   <= p1_dv_ff * p1_dv_ff;
      p2_sa_ff   <= p1_da_ff * p1_da_ff;
      p2_si_ff   <= p1_di_ff * p1_di_ff;
   end

   // sum of squares against the squared radius
   assign dist2 = {2'b00, p2_sv_ff} + {2'b00, p2_sa_ff} + {2'b00, p2_si_ff};
   assign hit   = dist2 < {2'b00, thr2_ff};

   // mask accumulator for the current word
   always_ff @(posedge clock) begin
      if (cmd.query_start || cmd.emit_hit) begin
         acc_ff <= '0;
      end else if (p2_valid_ff && hit && !p2_excl_ff) begin
         acc_ff[p2_bit_ff] <= 1'b1;
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_hit || cmd.emit_miss) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_hit) begin
         rsp_mask_ff  <= acc_ff;
         rsp_word_ff  <= word_ff;
         rsp_found_ff <= 1'b1;
         rsp_last_ff  <= last_ff;
      end else if (cmd.emit_miss) begin
         rsp_mask_ff  <= '0;
         rsp_word_ff  <= '0;
         rsp_found_ff <= 1'b0;
         rsp_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_mask   = rsp_mask_ff;
   assign rsp_word_index   = rsp_word_ff;
   assign rsp_source_found = rsp_found_ff;
   assign rsp_last         = rsp_last_ff;

   // status to the controller
   assign status.src_found = {1'b0, req_node_index} < cfg.count;
   assign status.word_end  = (&scan_id_ff[BIT_W-1:0]) || query_end;
   assign status.pipe_busy = p0_valid_ff || p1_valid_ff || p2_valid_ff;
   assign status.out_free  = out_free;
   assign status.last      = last_ff;

endmodule
`default_nettype wire

### design/fixed_radius_point_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_radius_point_search
// Table of up to 256 points with three Q2.14 coordinates; a query returns
// one 64-bit mask per group of 64 points in use, marking points other than
// the source whose squared distance to it is below the squared threshold.
// ----------------------------------------------------------------------------
//
//   port group  direction  handshake           payload
//   req_*       in         req_valid/req_stall cmd, node_index, coordinates
//   rsp_*       out        rsp_valid/rsp_stall match_mask, word_index,
//                                              source_found, last
//   csr_*       in/out     psel/penable        threshold @0x0, node_count @0x4
//
// a write item is taken while idle; an unknown source gives its one item
// through the miss state and the output register. a query scans one point
// per cycle through the single table read port, and each mask word waits
// on the distance pipeline to drain.
// reset is synchronous; the point table is not cleared. a stalled result
// holds in its output register while the block takes the next item.
// ----------------------------------------------------------------------------
module fixed_radius_point_search
   import frps_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_cmd,
   input  wire logic        [IDX_W-1:0]   req_node_index,
   input  wire logic signed [COORD_W-1:0] req_valence,
   input  wire logic signed [COORD_W-1:0] req_arousal,
   input  wire logic signed [COORD_W-1:0] req_intensity,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [WORD_BITS-1:0]           rsp_match_mask,
   output logic [WIDX_W-1:0]              rsp_word_index,
   output logic                           rsp_source_found,
   output logic                           rsp_last,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [2:0]                csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output logic      [31:0]               csr_prdata,
   output logic                           csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // configuration registers
   frps_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer
   frps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // table and distance datapath
   frps_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_node_index   (req_node_index),
      .req_valence      (req_valence),
      .req_arousal      (req_arousal),
      .req_intensity    (req_intensity),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_match_mask   (rsp_match_mask),
      .rsp_word_index   (rsp_word_index),
      .rsp_source_found (rsp_source_found),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire
